// ===== rtl/core/utrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and constants for the UART transmit/receive ring buffer block.
// ----------------------------------------------------------------------------
package utrb_pkg;

   localparam int LEVEL_W = 7;

   typedef enum logic [1:0] {
      REQ_PUT    = 2'd0,
      REQ_GET    = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_ARRIVE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

// ===== rtl/core/utrb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_ctrl
// Request sequencer: capture, execute against the rings, load the result.
// ----------------------------------------------------------------------------
module utrb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    rsp_stall,
   input  utrb_pkg::dp_status_type status,
   output utrb_pkg::dp_cmd_type    cmd
);
   import utrb_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!status.rsp_busy || !rsp_stall) begin
               cmd.load  = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/utrb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_dp
// Ring storage, pointers, flags and the result register.
// ----------------------------------------------------------------------------
module utrb_dp #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  utrb_pkg::dp_cmd_type      cmd,
   output utrb_pkg::dp_status_type   status,
   input  logic [1:0]                req_type,
   input  logic [7:0]                req_data_byte,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic                      rsp_line_tx_valid,
   output logic [7:0]                rsp_line_tx_byte,
   output logic                      rsp_read_valid,
   output logic [7:0]                rsp_read_byte,
   output logic                      rsp_put_accepted,
   output logic                      rsp_sending,
   output logic                      rsp_received,
   output logic                      rsp_overrun,
   output logic [utrb_pkg::LEVEL_W-1:0] rsp_rx_level,
   output logic [utrb_pkg::LEVEL_W-1:0] rsp_tx_level
);
   import utrb_pkg::*;

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   req_kind_type     kind_ff;
   logic [7:0]       data_ff;

   logic [RX_AW-1:0] rx_head_ff, rx_head_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic             busy_ff, busy_in;
   logic             got_ff, got_in;
   logic             ovr_ff, ovr_in;

   logic pend_txv_ff, pend_txv_in;
   logic pend_byp_ff, pend_byp_in;
   logic pend_rdv_ff, pend_rdv_in;
   logic pend_acc_ff, pend_acc_in;

   logic [7:0] tx_rd_ff;
   logic [7:0] rx_rd_ff;

   logic tx_we, rx_we;
   logic [TX_AW:0]   tx_sum;
   logic [RX_AW:0]   rx_sum;
   logic [TX_AW-1:0] tx_tail, tx_head_nxt;
   logic [RX_AW-1:0] rx_tail, rx_head_nxt;

   logic rsp_valid_ff;
   logic rsp_txv_ff, rsp_rdv_ff, rsp_acc_ff, rsp_busy_ff, rsp_got_ff, rsp_ovr_ff;
   logic [7:0] rsp_txb_ff, rsp_rdb_ff, rsp_txb_in, rsp_rdb_in;
   logic [LEVEL_W-1:0] rsp_rxl_ff, rsp_txl_ff;

   always_comb begin
      tx_sum = (TX_AW+1)'(tx_head_ff) + (TX_AW+1)'(tx_count_ff);
      rx_sum = (RX_AW+1)'(rx_head_ff) + (RX_AW+1)'(rx_count_ff);
      tx_tail = (tx_sum >= (TX_AW+1)'(TX_DEPTH)) ?
                TX_AW'(tx_sum - (TX_AW+1)'(TX_DEPTH)) : TX_AW'(tx_sum);
      rx_tail = (rx_sum >= (RX_AW+1)'(RX_DEPTH)) ?
                RX_AW'(rx_sum - (RX_AW+1)'(RX_DEPTH)) : RX_AW'(rx_sum);
      tx_head_nxt = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_ff + TX_AW'(1);
      rx_head_nxt = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_ff + RX_AW'(1);
   end

   always_comb begin
      rx_head_in  = rx_head_ff;
      rx_count_in = rx_count_ff;
      tx_head_in  = tx_head_ff;
      tx_count_in = tx_count_ff;
      busy_in     = busy_ff;
      got_in      = got_ff;
      ovr_in      = ovr_ff;
      pend_txv_in = 1'b0;
      pend_byp_in = 1'b0;
      pend_rdv_in = 1'b0;
      pend_acc_in = 1'b0;
      tx_we       = 1'b0;
      rx_we       = 1'b0;
      case (kind_ff)
         REQ_PUT: begin
            if (tx_count_ff < TX_CW'(TX_DEPTH)) begin
               tx_we       = 1'b1;
               pend_acc_in = 1'b1;
               if (!busy_ff) begin
                  busy_in     = 1'b1;
                  pend_txv_in = 1'b1;
                  pend_byp_in = (tx_count_ff == '0);
                  tx_head_in  = tx_head_nxt;
               end else begin
                  tx_count_in = tx_count_ff + TX_CW'(1);
               end
            end
         end
         REQ_GET: begin
            if (rx_count_ff != '0) begin
               pend_rdv_in = 1'b1;
               rx_head_in  = rx_head_nxt;
               rx_count_in = rx_count_ff - RX_CW'(1);
               if (rx_count_ff == RX_CW'(1)) begin
                  got_in = 1'b0;
               end
            end
         end
         REQ_TICK: begin
            if (tx_count_ff != '0) begin
               busy_in     = 1'b1;
               pend_txv_in = 1'b1;
               tx_head_in  = tx_head_nxt;
               tx_count_in = tx_count_ff - TX_CW'(1);
            end else begin
               busy_in = 1'b0;
            end
         end
         REQ_ARRIVE: begin
            got_in = 1'b1;
            if (rx_count_ff == RX_CW'(RX_DEPTH)) begin
               ovr_in = 1'b1;
            end else begin
               rx_we       = 1'b1;
               rx_count_in = rx_count_ff + RX_CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind_type'(req_type);
         data_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         tx_rd_ff <= tx_mem[tx_head_ff];
         rx_rd_ff <= rx_mem[rx_head_ff];
         if (tx_we) begin
            tx_mem[tx_tail] <= data_ff;
         end
         if (rx_we) begin
            rx_mem[rx_tail] <= data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff  <= '0;
         rx_count_ff <= '0;
         tx_head_ff  <= '0;
         tx_count_ff <= '0;
         busy_ff     <= 1'b0;
         got_ff      <= 1'b0;
         ovr_ff      <= 1'b0;
         pend_txv_ff <= 1'b0;
         pend_byp_ff <= 1'b0;
         pend_rdv_ff <= 1'b0;
         pend_acc_ff <= 1'b0;
      end else if (cmd.exec) begin
         rx_head_ff  <= rx_head_in;
         rx_count_ff <= rx_count_in;
         tx_head_ff  <= tx_head_in;
         tx_count_ff <= tx_count_in;
         busy_ff     <= busy_in;
         got_ff      <= got_in;
         ovr_ff      <= ovr_in;
         pend_txv_ff <= pend_txv_in;
         pend_byp_ff <= pend_byp_in;
         pend_rdv_ff <= pend_rdv_in;
         pend_acc_ff <= pend_acc_in;
      end
   end

   // result beat
   assign rsp_txb_in = !pend_txv_ff ? 8'h00 : (pend_byp_ff ? data_ff : tx_rd_ff);
   assign rsp_rdb_in = pend_rdv_ff ? rx_rd_ff : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_txv_ff  <= pend_txv_ff;
         rsp_txb_ff  <= rsp_txb_in;
         rsp_rdv_ff  <= pend_rdv_ff;
         rsp_rdb_ff  <= rsp_rdb_in;
         rsp_acc_ff  <= pend_acc_ff;
         rsp_busy_ff <= busy_ff;
         rsp_got_ff  <= got_ff;
         rsp_ovr_ff  <= ovr_ff;
         rsp_rxl_ff  <= LEVEL_W'(rx_count_ff);
         rsp_txl_ff  <= LEVEL_W'(tx_count_ff);
      end
   end

   assign status.rsp_busy   = rsp_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_tx_valid = rsp_txv_ff;
   assign rsp_line_tx_byte  = rsp_txb_ff;
   assign rsp_read_valid    = rsp_rdv_ff;
   assign rsp_read_byte     = rsp_rdb_ff;
   assign rsp_put_accepted  = rsp_acc_ff;
   assign rsp_sending       = rsp_busy_ff;
   assign rsp_received      = rsp_got_ff;
   assign rsp_overrun       = rsp_ovr_ff;
   assign rsp_rx_level      = rsp_rxl_ff;
   assign rsp_tx_level      = rsp_txl_ff;

endmodule

// ===== rtl/core/uart_tx_rx_ring_buffers_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_top
// UART transmit and receive ring buffers driven by one request per beat.
// ----------------------------------------------------------------------------
// Sequencing: a request is captured on acceptance, executed against the rings
// with the ring memory read into registers, then loaded into the result
// register once no earlier beat is held by rsp_stall. New requests are taken
// when idle or as a result loads. Reset: rings empty, flags and pointers
// cleared, no result pending; ring contents are not cleared.
module uart_tx_rx_ring_buffers_top #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [7:0]                   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_line_tx_valid,
   output logic [7:0]                   rsp_line_tx_byte,
   output logic                         rsp_read_valid,
   output logic [7:0]                   rsp_read_byte,
   output logic                         rsp_put_accepted,
   output logic                         rsp_sending,
   output logic                         rsp_received,
   output logic                         rsp_overrun,
   output logic [utrb_pkg::LEVEL_W-1:0] rsp_rx_level,
   output logic [utrb_pkg::LEVEL_W-1:0] rsp_tx_level
);
   import utrb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   utrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   utrb_dp #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_line_tx_valid (rsp_line_tx_valid),
      .rsp_line_tx_byte  (rsp_line_tx_byte),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_put_accepted  (rsp_put_accepted),
      .rsp_sending       (rsp_sending),
      .rsp_received      (rsp_received),
      .rsp_overrun       (rsp_overrun),
      .rsp_rx_level      (rsp_rx_level),
      .rsp_tx_level      (rsp_tx_level)
   );

endmodule

// ===== rtl/core/utrb_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_check
// Port-level checks for the UART ring buffer block, bound to the top level.
// ----------------------------------------------------------------------------
module utrb_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_type,
   input logic [7:0]                   req_data_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_line_tx_valid,
   input logic [7:0]                   rsp_line_tx_byte,
   input logic                         rsp_read_valid,
   input logic [7:0]                   rsp_read_byte,
   input logic                         rsp_put_accepted,
   input logic                         rsp_sending,
   input logic                         rsp_received,
   input logic                         rsp_overrun,
   input logic [utrb_pkg::LEVEL_W-1:0] rsp_rx_level,
   input logic [utrb_pkg::LEVEL_W-1:0] rsp_tx_level
);
   import utrb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_tx_byte)
         && $stable(rsp_read_byte) && $stable(rsp_tx_level))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_tx_implies_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_tx_valid |-> rsp_sending)
      else $error("byte sent while transmitter idle");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_byte == 8'h00)
      else $error("read byte nonzero without a read");

   a_overrun_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overrun |=> !rsp_valid || rsp_overrun)
      else $error("overrun flag dropped");

endmodule

bind uart_tx_rx_ring_buffers_top utrb_check u_utrb_check (.*);
